@@ rtl/core/bst_pkg.sv @@
// shared types, constants and helpers for the build script tokenizer
// no dependencies; imported by every module of the block
package bst_pkg;

	// position counter width and limits
	localparam int unsigned POS_W = 32;
	localparam int unsigned OUT_W = 32;
	typedef logic [POS_W-1:0] pos_t;
	localparam pos_t POS_MAX = '1;

	// request queue depth between front and back
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);

	// token kinds
	localparam logic [3:0] KIND_IDENT       = 4'd0;
	localparam logic [3:0] KIND_DOT         = 4'd1;
	localparam logic [3:0] KIND_COMMA       = 4'd2;
	localparam logic [3:0] KIND_PLUS        = 4'd3;
	localparam logic [3:0] KIND_MINUS       = 4'd4;
	localparam logic [3:0] KIND_EQUALS      = 4'd5;
	localparam logic [3:0] KIND_LPAREN      = 4'd6;
	localparam logic [3:0] KIND_RPAREN      = 4'd7;
	localparam logic [3:0] KIND_STRING      = 4'd8;
	localparam logic [3:0] KIND_BAD_COMMENT = 4'd9;
	localparam logic [3:0] KIND_BAD_STRING  = 4'd10;
	localparam logic [3:0] KIND_BAD_CHAR    = 4'd11;

	// character codes
	localparam logic [20:0] CH_TAB    = 21'h09;
	localparam logic [20:0] CH_LF     = 21'h0A;
	localparam logic [20:0] CH_CR     = 21'h0D;
	localparam logic [20:0] CH_SPACE  = 21'h20;
	localparam logic [20:0] CH_QUOTE  = 21'h22;
	localparam logic [20:0] CH_LPAREN = 21'h28;
	localparam logic [20:0] CH_RPAREN = 21'h29;
	localparam logic [20:0] CH_STAR   = 21'h2A;
	localparam logic [20:0] CH_PLUS   = 21'h2B;
	localparam logic [20:0] CH_COMMA  = 21'h2C;
	localparam logic [20:0] CH_MINUS  = 21'h2D;
	localparam logic [20:0] CH_DOT    = 21'h2E;
	localparam logic [20:0] CH_SLASH  = 21'h2F;
	localparam logic [20:0] CH_ZERO   = 21'h30;
	localparam logic [20:0] CH_NINE   = 21'h39;
	localparam logic [20:0] CH_EQUALS = 21'h3D;
	localparam logic [20:0] CH_UPPER_A = 21'h41;
	localparam logic [20:0] CH_UPPER_Z = 21'h5A;
	localparam logic [20:0] CH_BSLASH = 21'h5C;
	localparam logic [20:0] CH_USCORE = 21'h5F;
	localparam logic [20:0] CH_LOWER_A = 21'h61;
	localparam logic [20:0] CH_LOWER_Z = 21'h7A;

	// input character request
	typedef struct packed {
		logic [20:0] char_code;
		logic        end_of_input;
	} char_item_t;

	// output token request
	typedef struct packed {
		logic [3:0]       token_kind;
		logic [OUT_W-1:0] start_offset;
		logic [OUT_W-1:0] start_line;
		logic [OUT_W-1:0] start_column;
		logic [OUT_W-1:0] token_length;
		logic             last_of_run;
	} tok_item_t;

	// one queue entry: the tokens caused by one character
	typedef struct packed {
		logic      two;
		tok_item_t tok0;
		tok_item_t tok1;
	} qent_t;

	// front to queue write side
	typedef struct packed {
		logic  push;
		qent_t ent;
	} push_t;

	// queue head towards the back
	typedef struct packed {
		logic  avail;
		qent_t ent;
	} head_t;

	// low output bits of a position counter
	function automatic logic [OUT_W-1:0] out_bits(input pos_t v);
		logic [63:0] w;
		w = 64'(v);
		return w[OUT_W-1:0];
	endfunction

	// saturating increment
	function automatic pos_t sat_inc(input pos_t v);
		return (v == POS_MAX) ? v : v + pos_t'(1);
	endfunction

endpackage

@@ rtl/core/bst_front.sv @@
// front end: takes characters, tracks positions and runs the lexer modes
// depends on bst_pkg; pushes the tokens of each character into the queue
module bst_front import bst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  char_item_t char_item,
	output push_t      push
);

	typedef enum logic [3:0] {
		M_IDLE,
		M_SLASH,
		M_LINE,
		M_BLOCK,
		M_BLOCK_STAR,
		M_STRING,
		M_STRING_ESC,
		M_IDENT,
		M_HALT
	} mode_t;

	mode_t mode_q;
	pos_t  off_q, line_q, col_q, tso_q, tsl_q, tsc_q, len_q;

	mode_t     mode_v;
	pos_t      off_v, line_v, col_v, tso_v, tsl_v, tsc_v, len_v;
	logic [1:0] n_v;
	logic      do_idle;
	logic      is_lf;
	logic [20:0] c;
	logic [3:0] sym_v;
	tok_item_t toks_v [2];

	function automatic tok_item_t mk_tok(input logic [3:0] kind, input pos_t so,
			input pos_t sl, input pos_t sc, input pos_t ln);
		tok_item_t t;
		t.token_kind   = kind;
		t.start_offset = out_bits(so);
		t.start_line   = out_bits(sl);
		t.start_column = out_bits(sc);
		t.token_length = out_bits(ln);
		t.last_of_run  = 1'b0;
		return t;
	endfunction

	function automatic logic [3:0] symbol_kind(input logic [20:0] ch);
		logic [3:0] k;
		case (ch)
			CH_DOT:    k = KIND_DOT;
			CH_COMMA:  k = KIND_COMMA;
			CH_PLUS:   k = KIND_PLUS;
			CH_MINUS:  k = KIND_MINUS;
			CH_EQUALS: k = KIND_EQUALS;
			CH_LPAREN: k = KIND_LPAREN;
			CH_RPAREN: k = KIND_RPAREN;
			default:   k = KIND_IDENT;
		endcase
		return k;
	endfunction

	function automatic logic ident_start(input logic [20:0] ch);
		return (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) ||
			(ch >= CH_UPPER_A && ch <= CH_UPPER_Z) || ch == CH_USCORE;
	endfunction

	function automatic logic ident_char(input logic [20:0] ch);
		return ident_start(ch) || (ch >= CH_ZERO && ch <= CH_NINE);
	endfunction

	// next state and tokens for one character
	always_comb begin
		c       = char_item.char_code;
		is_lf   = (c == CH_LF);
		mode_v  = mode_q;
		tso_v   = tso_q;
		tsl_v   = tsl_q;
		tsc_v   = tsc_q;
		len_v   = len_q;
		n_v     = 2'd0;
		do_idle = 1'b0;
		sym_v   = symbol_kind(c);
		toks_v[0] = mk_tok(KIND_IDENT, '0, '0, '0, '0);
		toks_v[1] = mk_tok(KIND_IDENT, '0, '0, '0, '0);

		// position advance, line feed takes column 1 of the new line
		if (is_lf) begin
			line_v = sat_inc(line_q);
			col_v  = '0;
		end else begin
			line_v = line_q;
			col_v  = col_q;
		end
		col_v = sat_inc(col_v);
		if (off_q == POS_MAX) begin
			off_v = '0;
		end else if (off_q < POS_MAX - pos_t'(1)) begin
			off_v = off_q + pos_t'(1);
		end else begin
			off_v = off_q;
		end

		// mode handling
		case (mode_q)
			M_SLASH: begin
				if (c == CH_SLASH) begin
					mode_v = M_LINE;
				end else if (c == CH_STAR) begin
					len_v  = sat_inc(len_v);
					mode_v = M_BLOCK;
				end else begin
					toks_v[n_v[0]] = mk_tok(KIND_BAD_CHAR, tso_v, tsl_v, tsc_v, len_v);
					n_v    = n_v + 2'd1;
					mode_v = M_HALT;
				end
			end
			M_LINE: begin
				if (is_lf) begin
					mode_v = M_IDLE;
				end
			end
			M_BLOCK, M_BLOCK_STAR: begin
				len_v = sat_inc(len_v);
				if (mode_q == M_BLOCK_STAR && c == CH_SLASH) begin
					mode_v = M_IDLE;
				end else begin
					mode_v = (c == CH_STAR) ? M_BLOCK_STAR : M_BLOCK;
				end
			end
			M_STRING, M_STRING_ESC: begin
				if (c == CH_QUOTE && mode_q == M_STRING) begin
					len_v = sat_inc(len_v);
					toks_v[n_v[0]] = mk_tok(KIND_STRING, tso_v, tsl_v, tsc_v, len_v);
					n_v    = n_v + 2'd1;
					mode_v = M_IDLE;
				end else if (is_lf && mode_q == M_STRING) begin
					toks_v[n_v[0]] = mk_tok(KIND_BAD_STRING, tso_v, tsl_v, tsc_v, len_v);
					n_v    = n_v + 2'd1;
					mode_v = M_HALT;
				end else begin
					len_v  = sat_inc(len_v);
					mode_v = (c == CH_BSLASH) ? M_STRING_ESC : M_STRING;
				end
			end
			M_IDENT: begin
				if (ident_char(c)) begin
					len_v = sat_inc(len_v);
				end else begin
					toks_v[n_v[0]] = mk_tok(KIND_IDENT, tso_v, tsl_v, tsc_v, len_v);
					n_v     = n_v + 2'd1;
					mode_v  = M_IDLE;
					do_idle = 1'b1;
				end
			end
			M_HALT: begin
				mode_v = M_HALT;
			end
			default: begin
				mode_v  = M_IDLE;
				do_idle = 1'b1;
			end
		endcase

		// idle handling: a new token starts at this character
		if (do_idle && !(is_lf || c == CH_SPACE || c == CH_TAB || c == CH_CR)) begin
			tso_v = off_v;
			tsl_v = line_v;
			tsc_v = col_v;
			len_v = pos_t'(1);
			if (c == CH_SLASH) begin
				mode_v = M_SLASH;
			end else if (sym_v != KIND_IDENT) begin
				toks_v[n_v[0]] = mk_tok(sym_v, tso_v, tsl_v, tsc_v, len_v);
				n_v    = n_v + 2'd1;
				mode_v = M_IDLE;
			end else if (c == CH_QUOTE) begin
				mode_v = M_STRING;
			end else if (ident_start(c)) begin
				mode_v = M_IDENT;
			end else begin
				toks_v[n_v[0]] = mk_tok(KIND_BAD_CHAR, tso_v, tsl_v, tsc_v, len_v);
				n_v    = n_v + 2'd1;
				mode_v = M_HALT;
			end
		end

		// end of input flushes the open token and restarts positions
		if (char_item.end_of_input) begin
			case (mode_v)
				M_SLASH: begin
					toks_v[n_v[0]] = mk_tok(KIND_BAD_CHAR, tso_v, tsl_v, tsc_v, len_v);
					n_v = n_v + 2'd1;
				end
				M_BLOCK, M_BLOCK_STAR: begin
					toks_v[n_v[0]] = mk_tok(KIND_BAD_COMMENT, tso_v, tsl_v, tsc_v, len_v);
					n_v = n_v + 2'd1;
				end
				M_STRING, M_STRING_ESC: begin
					toks_v[n_v[0]] = mk_tok(KIND_BAD_STRING, tso_v, tsl_v, tsc_v, len_v);
					n_v = n_v + 2'd1;
				end
				M_IDENT: begin
					toks_v[n_v[0]] = mk_tok(KIND_IDENT, tso_v, tsl_v, tsc_v, len_v);
					n_v = n_v + 2'd1;
				end
				default: begin
					n_v = n_v;
				end
			endcase
			mode_v = M_IDLE;
			off_v  = POS_MAX;
			line_v = pos_t'(1);
			col_v  = '0;
			tso_v  = '0;
			tsl_v  = '0;
			tsc_v  = '0;
			len_v  = '0;
		end

		// mark the final token of this character
		if (n_v == 2'd1) begin
			toks_v[0].last_of_run = 1'b1;
		end else if (n_v == 2'd2) begin
			toks_v[1].last_of_run = 1'b1;
		end

		push.push     = take && (n_v != 2'd0);
		push.ent.two  = n_v[1];
		push.ent.tok0 = toks_v[0];
		push.ent.tok1 = toks_v[1];
	end

	// lexer state and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			off_q  <= POS_MAX;
			line_q <= pos_t'(1);
			col_q  <= '0;
			tso_q  <= '0;
			tsl_q  <= '0;
			tsc_q  <= '0;
			len_q  <= '0;
		end else if (take) begin
			mode_q <= mode_v;
			off_q  <= off_v;
			line_q <= line_v;
			col_q  <= col_v;
			tso_q  <= tso_v;
			tsl_q  <= tsl_v;
			tsc_q  <= tsc_v;
			len_q  <= len_v;
		end
	end

endmodule

@@ rtl/core/bst_queue.sv @@
// short queue of token groups between the front and the back
// depends on bst_pkg; one push and one pop per cycle
module bst_queue import bst_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	input  logic  pop,
	output head_t head,
	output logic  full
);

	qent_t             store_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   count_q;

	assign full       = (count_q == (QPTR_W+1)'(QDEPTH));
	assign head.avail = (count_q != '0);
	assign head.ent   = store_q[rd_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push.push) begin
			store_q[wr_q] <= push.ent;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push.push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			case ({push.push, pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/core/bst_back.sv @@
// back end: splits queue entries into single tokens on the output register
// depends on bst_pkg; reads the queue head and drives the token channel
module bst_back import bst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  head_t     head,
	output logic      pop,
	output logic      tok_valid,
	input  logic      tok_stall,
	output tok_item_t tok_item
);

	logic      valid_q;
	logic      sel_q;
	tok_item_t out_q;
	logic      load;
	tok_item_t next_tok;

	// load the output register when it is empty or being taken
	assign load     = head.avail && (!valid_q || !tok_stall);
	assign next_tok = sel_q ? head.ent.tok1 : head.ent.tok0;
	assign pop      = load && (!head.ent.two || sel_q);

	assign tok_valid = valid_q;
	assign tok_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sel_q   <= head.ent.two && !sel_q;
			end else if (!tok_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= next_tok;
		end
	end

endmodule

@@ rtl/core/build_script_tokenizer_unit.sv @@
// build script tokenizer: one character in and one token out per cycle unless stalled
// a token enters the queue as its character is accepted, then moves to the output register
// throughput: one character per cycle while the queue has room; a character causing
// two tokens holds the output for both, absorbed by the four-entry front-back queue
// reset: asynchronous, clears lexer mode, positions, queue and output; no clear pass
module build_script_tokenizer_unit import bst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  char_item_t char_item,
	output logic       tok_valid,
	input  logic       tok_stall,
	output tok_item_t  tok_item
);

	push_t push;
	head_t head;
	logic  pop;
	logic  full;

	// input stalls only on a full queue
	assign char_stall = full;

	bst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (char_valid && !char_stall),
		.char_item (char_item),
		.push      (push)
	);

	bst_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.full   (full)
	);

	bst_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_item  (tok_item)
	);

endmodule

@@ rtl/core/bst_chk.sv @@
// port-level checks for the build script tokenizer
// depends on bst_pkg; bound to build_script_tokenizer_unit below
module bst_chk import bst_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       char_stall,
	input logic       tok_valid,
	input logic       tok_stall,
	input tok_item_t  tok_item
);

	// a stalled token holds
	a_tok_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_stall |=> tok_valid && $stable(tok_item))
		else $error("token changed under stall");

	// a full queue always has a token waiting on the output
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> tok_valid)
		else $error("input stalled with no token on the output");

	// only defined kinds leave the block
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> tok_item.token_kind <= KIND_BAD_CHAR)
		else $error("undefined token kind");

	// symbols cover exactly one character, with real line and column
	a_symbol_len: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_item.token_kind >= KIND_DOT && tok_item.token_kind <= KIND_RPAREN
		|-> tok_item.token_length == OUT_W'(1) && tok_item.start_line != '0 &&
			tok_item.start_column != '0)
		else $error("bad symbol token");

	// a complete string holds at least both quotes
	a_string_len: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_item.token_kind == KIND_STRING |-> tok_item.token_length >= OUT_W'(2))
		else $error("string token too short");

endmodule

bind build_script_tokenizer_unit bst_chk u_chk (.*);
